FILE: hw/rtl/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants of the periodic deadline scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package pds_pkg;

  localparam int unsigned MAX_OUT = 16;
  localparam int unsigned OUT_CW  = 5;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_POP   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;
  localparam logic [1:0] FUNC_RESCH = 2'd3;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_TASK  = 2'd1;
  localparam logic [1:0] KIND_WAIT  = 2'd2;
  localparam logic [1:0] KIND_RESCH = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [31:0] deadline;
    logic [31:0] period;
    logic [31:0] fperiod;
    logic [31:0] lforced;
    logic [7:0]  dom;
    logic [7:0]  sub;
  } entry_t;

  typedef struct packed {
    logic all;
    logic deadline;
    logic lforced;
  } wr_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pds_table.sv
// ----------------------------------------------------------------------------
// pds_table
// Task table memories with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module pds_table import pds_pkg::*; #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IW = 4
) (
  input  wire logic          clk,
  input  wire wr_t           wr,
  input  wire logic [IW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [IW-1:0] raddr,
  output entry_t             rdata
);

  logic [31:0] deadline_mem [ENTRIES];
  logic [31:0] period_mem   [ENTRIES];
  logic [31:0] fperiod_mem  [ENTRIES];
  logic [31:0] lforced_mem  [ENTRIES];
  logic [7:0]  dom_mem      [ENTRIES];
  logic [7:0]  sub_mem      [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.all || wr.deadline) begin
      deadline_mem[waddr] <= wdata.deadline;
    end
    if (wr.all || wr.lforced) begin
      lforced_mem[waddr] <= wdata.lforced;
    end
    if (wr.all) begin
      period_mem[waddr]  <= wdata.period;
      fperiod_mem[waddr] <= wdata.fperiod;
      dom_mem[waddr]     <= wdata.dom;
      sub_mem[waddr]     <= wdata.sub;
    end
    rdata.deadline <= deadline_mem[raddr];
    rdata.period   <= period_mem[raddr];
    rdata.fperiod  <= fperiod_mem[raddr];
    rdata.lforced  <= lforced_mem[raddr];
    rdata.dom      <= dom_mem[raddr];
    rdata.sub      <= sub_mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/periodic_deadline_scheduler_core.sv
// ----------------------------------------------------------------------------
// periodic_deadline_scheduler_core
// Earliest-deadline-first scheduler over a table of periodic tasks.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// in_*     slave      tuser: func; tdata: now, ids, intervals, reschedule time
// out_*    master     tuser: kind; tlast: last; tdata: answer fields
//
// A load answers straight from the idle state; a query or reschedule scans the
// table once. A pop rescans the table for each due task, up to sixteen tasks,
// through the single table read port that the scan walks, and, unless sixteen
// were popped, once more to find no further due task. Each result waits in the
// output register; the sequencer resumes after it is taken. Reset is synchronous and empties the table at once.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_deadline_scheduler_core import pds_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // now[31:0], domain_id[39:32], subdomain_id[47:40], interval[79:48],
  // force_interval[111:80], resched_time[143:112]
  input  wire logic [143:0] in_tdata,
  // func[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status[1:0], task_domain[9:2], task_subdomain[17:10], forced[18],
  // wait_seconds[50:19], queue_empty[51], found[52], zero[55:53]
  output logic [55:0]       out_tdata,
  // kind[1:0]
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  logic [2:0]        state_r, ret_r;
  logic [CW-1:0]     cnt_r, iss_r;
  logic [IW-1:0]     chk_idx_r, best_r;
  logic              chk_vld_r, best_vld_r;
  logic [31:0]       best_dl_r;
  logic [ENTRIES-1:0] taken_r;
  logic [OUT_CW-1:0] pop_cnt_r;
  logic              pend_vld_r, pend_forced_r;
  logic [7:0]        pend_dom_r, pend_sub_r;
  logic [1:0]        func_r;
  logic [31:0]       now_r, nd_r;
  logic [7:0]        dom_r, sub_r;
  logic              out_tvalid_r, out_tlast_r;
  logic [55:0]       out_tdata_r;
  logic [1:0]        out_tuser_r;

  wr_t           wr;
  logic [IW-1:0] waddr, raddr;
  entry_t        wdata, rd;

  logic          in_acc, scan_done, due, better, match, forced;
  logic [32:0]   next_sum;
  logic [31:0]   next_dl, elapsed, ld_lf;
  logic [1:0]    ld_status;

  pds_table #(.ENTRIES(ENTRIES), .IW(IW)) u_table (
    .clk   (clk),
    .wr    (wr),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  assign in_tready = (state_r == S_IDLE) && !out_tvalid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  assign scan_done = (iss_r == cnt_r) && !chk_vld_r;
  assign due       = !(now_r < rd.deadline) && !taken_r[chk_idx_r];
  assign better    = !best_vld_r || (rd.deadline < best_dl_r);
  assign match     = (rd.dom == dom_r) && (rd.sub == sub_r);
  assign elapsed   = now_r - rd.lforced;
  assign forced    = (rd.fperiod != 32'd0) && (elapsed >= rd.fperiod);
  assign next_sum  = {1'b0, now_r} + {1'b0, rd.period};
  assign next_dl   = next_sum[32] ? 32'hFFFF_FFFF : next_sum[31:0];
  assign ld_lf     = (in_tdata[111:80] != 32'd0) ? in_tdata[31:0] - in_tdata[111:80] : 32'd0;

  always_comb begin
    if (in_tdata[79:48] == 32'd0) begin
      ld_status = ST_ZERO;
    end else if (cnt_r == CW'(ENTRIES)) begin
      ld_status = ST_FULL;
    end else begin
      ld_status = ST_OK;
    end
  end

  always_comb begin
    wr    = '0;
    waddr = best_r;
    raddr = (state_r == S_SCAN) ? iss_r[IW-1:0] : best_r;
    wdata.deadline = next_dl;
    wdata.period   = in_tdata[79:48];
    wdata.fperiod  = in_tdata[111:80];
    wdata.lforced  = now_r;
    wdata.dom      = in_tdata[39:32];
    wdata.sub      = in_tdata[47:40];
    if (in_acc && (in_tuser == FUNC_LOAD) && (ld_status == ST_OK)) begin
      wr.all         = 1'b1;
      waddr          = cnt_r[IW-1:0];
      wdata.deadline = in_tdata[31:0];
      wdata.lforced  = ld_lf;
    end else if (state_r == S_UPD) begin
      wr.deadline = 1'b1;
      wr.lforced  = forced;
    end else if ((state_r == S_SCAN) && chk_vld_r && (func_r == FUNC_RESCH) &&
                 !best_vld_r && match) begin
      wr.deadline    = 1'b1;
      waddr          = chk_idx_r;
      wdata.deadline = nd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      pend_vld_r   <= 1'b0;
      best_vld_r   <= 1'b0;
      pop_cnt_r    <= '0;
      taken_r      <= '0;
      iss_r        <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            func_r     <= in_tuser;
            now_r      <= in_tdata[31:0];
            dom_r      <= in_tdata[39:32];
            sub_r      <= in_tdata[47:40];
            nd_r       <= in_tdata[143:112];
            iss_r      <= '0;
            chk_vld_r  <= 1'b0;
            best_vld_r <= 1'b0;
            taken_r    <= '0;
            pop_cnt_r  <= '0;
            pend_vld_r <= 1'b0;
            if (in_tuser == FUNC_LOAD) begin
              out_tvalid_r <= 1'b1;
              out_tuser_r  <= KIND_LOAD;
              out_tlast_r  <= 1'b0;
              out_tdata_r  <= {54'd0, ld_status};
              ret_r        <= S_IDLE;
              state_r      <= S_WAIT;
              if (ld_status == ST_OK) begin
                cnt_r <= cnt_r + CW'(1);
              end
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (iss_r != cnt_r) begin
            chk_vld_r <= 1'b1;
            chk_idx_r <= iss_r[IW-1:0];
            iss_r     <= iss_r + CW'(1);
          end else begin
            chk_vld_r <= 1'b0;
          end
          if (chk_vld_r) begin
            case (func_r)
              FUNC_POP: begin
                if (due && better) begin
                  best_vld_r <= 1'b1;
                  best_dl_r  <= rd.deadline;
                  best_r     <= chk_idx_r;
                end
              end
              FUNC_QUERY: begin
                if (better) begin
                  best_vld_r <= 1'b1;
                  best_dl_r  <= rd.deadline;
                end
              end
              default: begin
                if (!best_vld_r && match) begin
                  best_vld_r <= 1'b1;
                end
              end
            endcase
          end
          if (scan_done) begin
            out_tlast_r <= 1'b0;
            ret_r       <= S_IDLE;
            if (func_r == FUNC_POP) begin
              out_tuser_r <= KIND_TASK;
              out_tdata_r <= {37'd0, pend_forced_r, pend_sub_r, pend_dom_r, ST_OK};
              if (best_vld_r) begin
                if (pend_vld_r) begin
                  out_tvalid_r <= 1'b1;
                  ret_r        <= S_FETCH;
                  state_r      <= S_WAIT;
                end else begin
                  state_r <= S_FETCH;
                end
              end else if (pend_vld_r) begin
                out_tvalid_r <= 1'b1;
                out_tlast_r  <= 1'b1;
                state_r      <= S_WAIT;
              end else begin
                state_r <= S_IDLE;
              end
            end else if (func_r == FUNC_QUERY) begin
              out_tvalid_r <= 1'b1;
              out_tuser_r  <= KIND_WAIT;
              out_tdata_r  <= {4'd0, !best_vld_r,
                               (best_vld_r && (best_dl_r > now_r)) ?
                               best_dl_r - now_r : 32'd0, 19'd0};
              state_r      <= S_WAIT;
            end else begin
              out_tvalid_r <= 1'b1;
              out_tuser_r  <= KIND_RESCH;
              out_tdata_r  <= {3'd0, best_vld_r, 52'd0};
              state_r      <= S_WAIT;
            end
          end
        end
        S_FETCH: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          taken_r[best_r] <= 1'b1;
          pop_cnt_r       <= pop_cnt_r + OUT_CW'(1);
          pend_vld_r      <= 1'b1;
          pend_dom_r      <= rd.dom;
          pend_sub_r      <= rd.sub;
          pend_forced_r   <= forced;
          iss_r           <= '0;
          chk_vld_r       <= 1'b0;
          best_vld_r      <= 1'b0;
          if (pop_cnt_r == OUT_CW'(MAX_OUT - 1)) begin
            out_tvalid_r <= 1'b1;
            out_tuser_r  <= KIND_TASK;
            out_tlast_r  <= 1'b1;
            out_tdata_r  <= {37'd0, forced, rd.sub, rd.dom, ST_OK};
            ret_r        <= S_IDLE;
            state_r      <= S_WAIT;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_WAIT: begin
          if (out_tready) begin
            out_tvalid_r <= 1'b0;
            state_r      <= ret_r;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid_r)
    else $error("input ready while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ENTRIES))
    else $error("entry count beyond table depth");

  a_pop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pop_cnt_r <= OUT_CW'(MAX_OUT))
    else $error("pop burst beyond limit");

  a_valid_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (state_r == S_WAIT))
    else $error("result shown outside the wait state");

endmodule
`default_nettype wire

FILE: test/tb_periodic_deadline_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_deadline_scheduler_core
// Streams load, pop, query and reschedule transactions into the scheduler. A
// behavioral copy of the task table predicts every answer, and each answer is
// checked field by field in arrival order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_periodic_deadline_scheduler_core;
  import pds_pkg::*;

  localparam int unsigned NENT = 16;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now;
    logic [7:0]  dom;
    logic [7:0]  sub;
    logic [31:0] ivl;
    logic [31:0] fivl;
    logic [31:0] nd;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [7:0]  dom;
    logic [7:0]  sub;
    logic        forced;
    logic        last;
    logic [31:0] wait_s;
    logic        empty;
    logic        found;
  } answer_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // now, domain_id, subdomain_id, interval, force_interval, resched_time
  logic [143:0] in_tdata;
  // func
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  // status, task_domain, task_subdomain, forced, wait_seconds, queue_empty,
  // found, zero
  logic [55:0] out_tdata;
  // kind
  logic [1:0] out_tuser;
  logic out_tlast;

  periodic_deadline_scheduler_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  cmd_t    pending_cmds[$];
  answer_t expected_answers[$];

  logic [31:0] tbl_deadline[NENT];
  logic [31:0] tbl_period[NENT];
  logic [31:0] tbl_fperiod[NENT];
  logic [31:0] tbl_lforced[NENT];
  logic [7:0]  tbl_dom[NENT];
  logic [7:0]  tbl_sub[NENT];
  int          tbl_count;

  int     errors;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_off;
  bit     send_pause;
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic answer_t blank_answer(logic [1:0] kind);
    answer_t a;
    a = '0;
    a.kind = kind;
    return a;
  endfunction

  task automatic queue_cmd(input cmd_t c);
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic expect_answer(input answer_t a);
    expected_answers = {expected_answers, a};
  endtask

  task automatic predict_schedule(input cmd_t c);
    answer_t a;
    bit      taken[NENT];
    int      order[$];
    int      best;
    logic [31:0] nearest;
    logic [32:0] nxt;
    a = blank_answer(KIND_LOAD);
    order = {};
    case (c.func)
      FUNC_LOAD: begin
        if (c.ivl == 0) begin
          a.status = ST_ZERO;
        end else if (tbl_count >= NENT) begin
          a.status = ST_FULL;
        end else begin
          tbl_deadline[tbl_count] = c.now;
          tbl_period[tbl_count] = c.ivl;
          tbl_fperiod[tbl_count] = c.fivl;
          tbl_lforced[tbl_count] = (c.fivl != 0) ? c.now - c.fivl : 32'd0;
          tbl_dom[tbl_count] = c.dom;
          tbl_sub[tbl_count] = c.sub;
          tbl_count++;
          a.status = ST_OK;
        end
        expect_answer(a);
      end
      FUNC_POP: begin
        foreach (taken[i]) taken[i] = 1'b0;
        while (order.size() < MAX_OUT) begin
          best = -1;
          for (int i = 0; i < tbl_count; i++) begin
            if (!taken[i] && c.now >= tbl_deadline[i] &&
                (best < 0 || tbl_deadline[i] < tbl_deadline[best])) best = i;
          end
          if (best < 0) break;
          taken[best] = 1'b1;
          order = {order, best};
        end
        foreach (order[k]) begin
          a = blank_answer(KIND_TASK);
          a.dom = tbl_dom[order[k]];
          a.sub = tbl_sub[order[k]];
          if (tbl_fperiod[order[k]] != 0 &&
              (c.now - tbl_lforced[order[k]]) >= tbl_fperiod[order[k]]) begin
            tbl_lforced[order[k]] = c.now;
            a.forced = 1'b1;
          end
          a.last = (k == order.size() - 1);
          expect_answer(a);
          nxt = {1'b0, c.now} + {1'b0, tbl_period[order[k]]};
          tbl_deadline[order[k]] = nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
        end
      end
      FUNC_QUERY: begin
        a = blank_answer(KIND_WAIT);
        if (tbl_count == 0) begin
          a.empty = 1'b1;
        end else begin
          nearest = tbl_deadline[0];
          for (int i = 1; i < tbl_count; i++)
            if (tbl_deadline[i] < nearest) nearest = tbl_deadline[i];
          a.wait_s = (nearest > c.now) ? nearest - c.now : 32'd0;
        end
        expect_answer(a);
      end
      default: begin
        a = blank_answer(KIND_RESCH);
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_dom[i] == c.dom && tbl_sub[i] == c.sub) begin
            tbl_deadline[i] = c.nd;
            a.found = 1'b1;
            break;
          end
        end
        expect_answer(a);
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_cmds.size() > 0 && !send_pause &&
          $urandom_range(99) >= send_idle_pct) begin
        cmd_t c;
        c = pending_cmds.pop_front();
        predict_schedule(c);
        in_tvalid <= 1'b1;
        in_tuser <= c.func;
        in_tdata <= {c.nd, c.fivl, c.ivl, c.sub, c.dom, c.now};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver readiness.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected transaction", {30'd0, out_tuser}, 32'd0);
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (out_tuser != e.kind) report_mismatch("kind", 32'(out_tuser), 32'(e.kind));
        if (out_tdata[1:0] != e.status)
          report_mismatch("status", 32'(out_tdata[1:0]), 32'(e.status));
        if (out_tdata[9:2] != e.dom)
          report_mismatch("task_domain", 32'(out_tdata[9:2]), 32'(e.dom));
        if (out_tdata[17:10] != e.sub)
          report_mismatch("task_subdomain", 32'(out_tdata[17:10]), 32'(e.sub));
        if (out_tdata[18] != e.forced)
          report_mismatch("forced", 32'(out_tdata[18]), 32'(e.forced));
        if (out_tlast != e.last) report_mismatch("last", 32'(out_tlast), 32'(e.last));
        if (out_tdata[50:19] != e.wait_s)
          report_mismatch("wait_seconds", out_tdata[50:19], e.wait_s);
        if (out_tdata[51] != e.empty)
          report_mismatch("queue_empty", 32'(out_tdata[51]), 32'(e.empty));
        if (out_tdata[52] != e.found)
          report_mismatch("found", 32'(out_tdata[52]), 32'(e.found));
        if (out_tdata[55:53] != 3'd0)
          report_mismatch("zero bits", 32'(out_tdata[55:53]), 32'd0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic cmd_t make_cmd(logic [1:0] func, logic [31:0] now, logic [7:0] dom,
                                    logic [7:0] sub, logic [31:0] ivl, logic [31:0] fivl,
                                    logic [31:0] nd);
    cmd_t c;
    c.func = func; c.now = now; c.dom = dom; c.sub = sub;
    c.ivl = ivl; c.fivl = fivl; c.nd = nd;
    return c;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom_range(20);
      1: return 32'hFFFF_FFFF - $urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || expected_answers.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // One random session: a well-formed timeline of loads, pops, queries and
  // reschedules on a small id space, salted with arbitrary items.
  task automatic add_random(input int count);
    logic [31:0] t;
    cmd_t c;
    t = $urandom_range(1000);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        c = make_cmd(2'($urandom_range(3)), rand_word(), 8'($urandom), 8'($urandom),
                     rand_word(), rand_word(), rand_word());
      end else begin
        t = t + $urandom_range(6);
        c = make_cmd(2'($urandom_range(3)), t, 8'($urandom_range(3)),
                     8'($urandom_range(3)), $urandom_range(8), $urandom_range(12),
                     t + $urandom_range(10));
        if ($urandom_range(15) == 0) c.ivl = 0;
      end
      queue_cmd(c);
    end
  endtask

  initial begin
    errors = 0;
    cycle_count = 0;
    hold_off = 0;
    send_pause = 1'b0;
    send_idle_pct = 14;
    recv_idle_pct = 76;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FUNC_LOAD;
    out_tready = 1'b0;
    tbl_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty query and pop, zero interval, ids at extremes, forcing,
    // saturating deadline, duplicate ids, table full and a full-burst pop.
    queue_cmd(make_cmd(FUNC_QUERY, 32'd5, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(FUNC_POP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(FUNC_LOAD, 32'd10, 8'hFF, 8'hFF, 32'd0, 32'd3, 0));
    queue_cmd(make_cmd(FUNC_RESCH, 32'd10, 8'h1, 8'h2, 0, 0, 32'd7));
    queue_cmd(make_cmd(FUNC_LOAD, 32'd10, 8'hFF, 8'hFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 0));
    queue_cmd(make_cmd(FUNC_LOAD, 32'd10, 8'h00, 8'h00, 32'd1, 32'd0, 0));
    queue_cmd(make_cmd(FUNC_LOAD, 32'd10, 8'h00, 8'h00, 32'd4, 32'd2, 0));
    queue_cmd(make_cmd(FUNC_QUERY, 32'd9, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(FUNC_POP, 32'd10, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(FUNC_POP, 32'd5, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(FUNC_RESCH, 32'd12, 8'h00, 8'h00, 0, 0, 32'd0));
    queue_cmd(make_cmd(FUNC_QUERY, 32'd12, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(FUNC_POP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    for (int i = 0; i < 14; i++)
      queue_cmd(make_cmd(FUNC_LOAD, 32'd20, 8'(i), 8'hA5, 32'd1, 32'd1, 0));
    queue_cmd(make_cmd(FUNC_LOAD, 32'd20, 8'h55, 8'h5A, 32'd1, 0, 0));
    queue_cmd(make_cmd(FUNC_RESCH, 32'd20, 8'hFF, 8'hFF, 0, 0,
                       32'hFFFF_FFFF));
    queue_cmd(make_cmd(FUNC_POP, 32'hFFFF_FFFE, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(FUNC_POP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));

    // Long receiver hold-off while the sender keeps offering.
    hold_off = 3000;
    wait_drained();

    // A reset-free way to empty the table is not available, so sessions
    // continue on the full table, where every load is rejected; keep ids small.
    add_random(70);
    wait_drained();
    send_idle_pct = 76;
    recv_idle_pct = 14;
    add_random(70);
    send_pause = 1'b1;
    while (expected_answers.size() > 0 || in_tvalid) @(posedge clk);
    send_pause = 1'b0;
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(60);
    wait_drained();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
